// ----- rtl/rti_pkg.sv -----
// shared widths, types and register indexes for the ray/triangle intersector
package rti_pkg;

    localparam int CW = 32;   // coordinate width, Q16.16
    localparam int EW = 33;   // edge and origin-offset width
    localparam int NW = 67;   // normal width, Q35.32
    localparam int DW = 102;  // determinant and numerator width, Q54.48
    localparam int PW = 134;  // dir * t numerator width, Q70.64
    localparam int RW = 136;  // divider remainder width
    localparam int QB = 34;   // quotient bits, top bit flags the clamp
    localparam int IW = 3;    // register index width

    // cyclic neighbors for cross products
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef enum logic [IW-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_DET_MIN  = 3'd6
    } rti_reg_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] neg;
    } rti_tag_t;

endpackage

// ----- rtl/rti_div_pipe.sv -----
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module rti_div_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  rti_pkg::rti_tag_t                   in_tag,
    input  logic [rti_pkg::DW-1:0]              in_d,
    input  logic [2:0][rti_pkg::PW-1:0]         in_mag,
    output logic                                out_valid,
    output rti_pkg::rti_tag_t                   out_tag,
    output logic [2:0][rti_pkg::QB-1:0]         out_q
);

    localparam int NS = rti_pkg::QB;

    logic                              v_reg   [NS];
    rti_pkg::rti_tag_t                 tag_reg [NS];
    logic [rti_pkg::DW-1:0]            d_reg   [NS];
    logic [2:0][rti_pkg::RW-1:0]       r_reg   [NS];
    logic [2:0][rti_pkg::QB-1:0]       q_reg   [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_step
        localparam int SH = NS - 1 - s;

        logic                          pv;
        rti_pkg::rti_tag_t             pt;
        logic [rti_pkg::DW-1:0]        pd;
        logic [2:0][rti_pkg::RW-1:0]   pr;
        logic [2:0][rti_pkg::QB-1:0]   pq;
        logic [rti_pkg::RW-1:0]        dsh;
        logic [2:0][rti_pkg::RW-1:0]   r_next;
        logic [2:0][rti_pkg::QB-1:0]   q_next;

        if (s == 0)
        begin : g_first
            assign pv = in_valid;
            assign pt = in_tag;
            assign pd = in_d;
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign pr[k] = rti_pkg::RW'(in_mag[k]);
                assign pq[k] = '0;
            end
        end
        else
        begin : g_rest
            assign pv = v_reg[s-1];
            assign pt = tag_reg[s-1];
            assign pd = d_reg[s-1];
            assign pr = r_reg[s-1];
            assign pq = q_reg[s-1];
        end

        assign dsh = rti_pkg::RW'(pd) << SH;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (pr[k] >= dsh)
                begin
                    r_next[k] = pr[k] - dsh;
                    q_next[k] = {pq[k][rti_pkg::QB-2:0], 1'b1};
                end
                else
                begin
                    r_next[k] = pr[k];
                    q_next[k] = {pq[k][rti_pkg::QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[s] <= pt;
                d_reg[s]   <= pd;
                r_reg[s]   <= r_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];
    assign out_q     = q_reg[NS-1];

endmodule

// ----- rtl/ray_triangle_intersect_mt.sv -----
// ray/triangle intersection with back-face culling, pipelined, one triangle per cycle
// pipeline: 9 arithmetic stages, 34 divider stages, one output register
// throughput: one item per cycle; the whole pipe stalls only while a result waits
// reset: ray registers return to origin 0, direction (0,0,1), det_min 1; pipe empties
module ray_triangle_intersect_mt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rti_pkg::IW-1:0]       cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           a_x,
    input  logic signed [31:0]           a_y,
    input  logic signed [31:0]           a_z,
    input  logic signed [31:0]           b_x,
    input  logic signed [31:0]           b_y,
    input  logic signed [31:0]           b_z,
    input  logic signed [31:0]           c_x,
    input  logic signed [31:0]           c_y,
    input  logic signed [31:0]           c_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic signed [31:0]           hit_x,
    output logic signed [31:0]           hit_y,
    output logic signed [31:0]           hit_z
);

    localparam int EW = rti_pkg::EW;
    localparam int NW = rti_pkg::NW;
    localparam int DW = rti_pkg::DW;
    localparam int PW = rti_pkg::PW;
    localparam int QB = rti_pkg::QB;

    function automatic logic signed [31:0] hit_coord(input logic signed [31:0] org,
                                                     input logic [QB-1:0] q,
                                                     input logic neg);
        logic [QB-1:0]     m;
        logic signed [35:0] mo;
        logic signed [35:0] s;
        m  = q[QB-1] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, q[QB-2:0]};
        mo = $signed(36'(m));
        s  = 36'(org) + (neg ? -mo : mo);
        if (s > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -36'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(s);
    endfunction

    // ray registers
    logic signed [31:0] origin_reg [3];
    logic signed [31:0] dir_reg    [3];
    logic [30:0]        det_min_reg;

    logic en;
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;

    logic signed [EW-1:0] s1_e1_reg [3];
    logic signed [EW-1:0] s1_e2_reg [3];
    logic signed [EW-1:0] s1_s_reg  [3];

    logic signed [EW-1:0] s2_e1_reg [3];
    logic signed [EW-1:0] s2_e2_reg [3];
    logic signed [EW-1:0] s2_s_reg  [3];
    logic signed [65:0]   np_reg    [3];
    logic signed [65:0]   nm_reg    [3];
    logic signed [64:0]   qp_reg    [3];
    logic signed [64:0]   qm_reg    [3];

    logic signed [EW-1:0] s3_e1_reg [3];
    logic signed [EW-1:0] s3_e2_reg [3];
    logic signed [EW-1:0] s3_s_reg  [3];
    logic signed [NW-1:0] n_reg     [3];
    logic signed [65:0]   q_reg     [3];

    logic signed [NW-1:0] wa [12];
    logic signed [EW-1:0] wb [12];
    logic signed [65:0]   pl_reg [12];
    logic signed [65:0]   pm_reg [12];
    logic signed [35:0]   ph_reg [12];

    logic signed [DW-1:0] pr_reg [12];

    logic signed [DW-1:0] d_reg, un_reg, vn_reg, tn_reg;

    logic [30:0]          det_eff;
    logic signed [DW-1:0] thr;
    logic signed [DW:0]   uv;
    logic                 hit_c;
    logic                 s7_hit_reg;
    logic [DW-1:0]        s7_d_reg;
    logic signed [64:0]   hp_reg [3][3];
    logic signed [37:0]   ht_reg [3];

    logic                 s8_hit_reg;
    logic [DW-1:0]        s8_d_reg;
    logic signed [PW-1:0] prod_reg [3];

    rti_pkg::rti_tag_t          s9_tag_reg;
    logic [DW-1:0]              s9_d_reg;
    logic [2:0][PW-1:0]         mag_reg;

    logic                       div_valid;
    rti_pkg::rti_tag_t          div_tag;
    logic [2:0][QB-1:0]         div_q;

    logic                       out_valid_reg;
    logic                       hit_reg;
    logic signed [31:0]         hc_reg [3];

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;

    assign va[0] = a_x; assign va[1] = a_y; assign va[2] = a_z;
    assign vb[0] = b_x; assign vb[1] = b_y; assign vb[2] = b_z;
    assign vc[0] = c_x; assign vc[1] = c_y; assign vc[2] = c_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= 32'sd65536;
            det_min_reg   <= 31'd1;
        end
        else if (cfg_valid)
        begin
            case (rti_pkg::rti_reg_t'(cfg_index))
                rti_pkg::REG_ORIGIN_X: origin_reg[0] <= $signed(cfg_data);
                rti_pkg::REG_ORIGIN_Y: origin_reg[1] <= $signed(cfg_data);
                rti_pkg::REG_ORIGIN_Z: origin_reg[2] <= $signed(cfg_data);
                rti_pkg::REG_DIR_X:    dir_reg[0]    <= $signed(cfg_data);
                rti_pkg::REG_DIR_Y:    dir_reg[1]    <= $signed(cfg_data);
                rti_pkg::REG_DIR_Z:    dir_reg[2]    <= $signed(cfg_data);
                rti_pkg::REG_DET_MIN:  det_min_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            out_valid_reg <= div_valid;
        end
    end

    // stages 1 to 3: edges, origin offset, cross products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_e1_reg[k] <= EW'(vb[k]) - EW'(va[k]);
                s1_e2_reg[k] <= EW'(vc[k]) - EW'(va[k]);
                s1_s_reg[k]  <= EW'(origin_reg[k]) - EW'(va[k]);

                s2_e1_reg[k] <= s1_e1_reg[k];
                s2_e2_reg[k] <= s1_e2_reg[k];
                s2_s_reg[k]  <= s1_s_reg[k];
                np_reg[k] <= s1_e1_reg[rti_pkg::NXT[k]] * s1_e2_reg[rti_pkg::PRV[k]];
                nm_reg[k] <= s1_e1_reg[rti_pkg::PRV[k]] * s1_e2_reg[rti_pkg::NXT[k]];
                qp_reg[k] <= s1_s_reg[rti_pkg::NXT[k]] * dir_reg[rti_pkg::PRV[k]];
                qm_reg[k] <= s1_s_reg[rti_pkg::PRV[k]] * dir_reg[rti_pkg::NXT[k]];

                s3_e1_reg[k] <= s2_e1_reg[k];
                s3_e2_reg[k] <= s2_e2_reg[k];
                s3_s_reg[k]  <= s2_s_reg[k];
                n_reg[k] <= NW'(np_reg[k]) - NW'(nm_reg[k]);
                q_reg[k] <= 66'(qp_reg[k]) - 66'(qm_reg[k]);
            end
        end
    end

    // operand pairs: det terms, u terms, v terms, t terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wa[k]     = n_reg[k];
            wb[k]     = EW'(dir_reg[k]);
            wa[3 + k] = NW'(q_reg[k]);
            wb[3 + k] = s3_e2_reg[k];
            wa[6 + k] = NW'(q_reg[k]);
            wb[6 + k] = s3_e1_reg[k];
            wa[9 + k] = n_reg[k];
            wb[9 + k] = s3_s_reg[k];
        end
    end

    // stages 4 to 6: split wide products, recombine, dot sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 12; j++)
            begin
                pl_reg[j] <= $signed({1'b0, wa[j][31:0]}) * wb[j];
                pm_reg[j] <= $signed({1'b0, wa[j][63:32]}) * wb[j];
                ph_reg[j] <= $signed(wa[j][NW-1:64]) * wb[j];
                pr_reg[j] <= DW'(pl_reg[j]) + (DW'(pm_reg[j]) <<< 32)
                           + (DW'(ph_reg[j]) <<< 64);
            end
            d_reg  <= -(pr_reg[0] + pr_reg[1] + pr_reg[2]);
            un_reg <= pr_reg[3] + pr_reg[4] + pr_reg[5];
            vn_reg <= -(pr_reg[6] + pr_reg[7] + pr_reg[8]);
            tn_reg <= pr_reg[9] + pr_reg[10] + pr_reg[11];
        end
    end

    // stage 7: hit test
    always_comb
    begin
        det_eff = (det_min_reg == '0) ? 31'd1 : det_min_reg;
        thr     = $signed(DW'({det_eff, 32'd0}));
        uv      = (DW + 1)'(un_reg) + (DW + 1)'(vn_reg);
        hit_c   = (d_reg >= thr) && !tn_reg[DW-1] && !un_reg[DW-1] && !vn_reg[DW-1]
                  && ((DW + 1)'(d_reg) >= uv);
    end

    // stages 7 to 9: dir * t numerator, magnitude and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_hit_reg <= hit_c;
            s7_d_reg   <= d_reg;
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                    hp_reg[k][c] <= $signed({1'b0, tn_reg[32*c +: 32]}) * dir_reg[k];
                ht_reg[k] <= $signed(tn_reg[DW-1:96]) * dir_reg[k];
            end

            s8_hit_reg <= s7_hit_reg;
            s8_d_reg   <= s7_d_reg;
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= PW'(hp_reg[k][0]) + (PW'(hp_reg[k][1]) <<< 32)
                             + (PW'(hp_reg[k][2]) <<< 64) + (PW'(ht_reg[k]) <<< 96);

            s9_tag_reg.hit <= s8_hit_reg;
            s9_d_reg       <= s8_d_reg;
            for (int k = 0; k < 3; k++)
            begin
                s9_tag_reg.neg[k] <= prod_reg[k][PW-1];
                mag_reg[k] <= prod_reg[k][PW-1] ? PW'(-prod_reg[k]) : PW'(prod_reg[k]);
            end
        end
    end

    rti_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_valid_reg),
        .in_tag    (s9_tag_reg),
        .in_d      (s9_d_reg),
        .in_mag    (mag_reg),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_q     (div_q)
    );

    // output register: clamp, add origin, saturate, zero on a miss
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= div_tag.hit;
            for (int k = 0; k < 3; k++)
                hc_reg[k] <= div_tag.hit ? hit_coord(origin_reg[k], div_q[k], div_tag.neg[k])
                                         : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hc_reg[0];
    assign hit_y     = hc_reg[1];
    assign hit_z     = hc_reg[2];

endmodule

// ----- rtl/rti_checker.sv -----
// port-level checker for the ray/triangle intersector and its bind
module rti_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    hit,
    input logic signed [31:0]      hit_x,
    input logic signed [31:0]      hit_y,
    input logic signed [31:0]      hit_z
);

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
        else $error("miss item with nonzero hit point");

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_x)
            && $stable(hit_y) && $stable(hit_z))
        else $error("result item changed while stalled");

    // a stalled result freezes the input side
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the pipe is stalled");

    // with no result waiting the pipe always takes an item
    a_flow_in: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with an empty output");

endmodule

bind ray_triangle_intersect_mt rti_checker u_rti_checker (.*);

// ----- tb/tb_ray_triangle_intersect_mt.sv -----
// testbench for the ray/triangle intersector: table-driven and random triangles vs a predictor
`timescale 1ns / 100ps

module tb_ray_triangle_intersect_mt;

    localparam int ONE = 65536;
    localparam logic [rti_pkg::IW-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE = 60;

    typedef logic signed [199:0] wint_t;
    typedef struct {
        logic signed [31:0] v [9];
    } tri_t;
    typedef struct {
        logic               hit;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } isect_t;
    typedef struct {
        tri_t   t;
        logic   typed;
        isect_t want;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [rti_pkg::IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [31:0] a_x = 0, a_y = 0, a_z = 0;
    logic signed [31:0] b_x = 0, b_y = 0, b_z = 0;
    logic signed [31:0] c_x = 0, c_y = 0, c_z = 0;
    logic out_valid;
    logic out_ready = 1;
    logic hit;
    logic signed [31:0] hit_x, hit_y, hit_z;

    // ray registers as the block should hold them
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic [30:0] det_floor;

    isect_t isect_q [$];
    int errors = 0;
    int n_tris = 0;
    int n_checked = 0;
    int n_hits = 0;
    int burst_left = 0;
    int cyc = 0;

    ray_triangle_intersect_mt dut (.*);

    always #6 clk = ~clk;

    function automatic logic signed [31:0] hit_coord(wint_t org, wint_t dk, wint_t tn,
                                                     wint_t dsc);
        wint_t prod, mag, s, cap;
        logic neg;
        cap = wint_t'(1) <<< 33;
        prod = dk * tn;
        neg = prod < 0;
        mag = neg ? -prod : prod;
        mag = mag / dsc;
        if (mag > cap)
            mag = cap;
        s = org + (neg ? -mag : mag);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic isect_t predict_isect(tri_t t);
        wint_t va [3], e1 [3], e2 [3], rel [3], dv [3], nrm [3], crs [3];
        wint_t dsc, un, vn, tn, thr;
        isect_t r;
        for (int k = 0; k < 3; k++)
        begin
            va[k] = wint_t'(t.v[k]);
            e1[k] = wint_t'(t.v[3+k]);
            e2[k] = wint_t'(t.v[6+k]);
            e1[k] = e1[k] - va[k];
            e2[k] = e2[k] - va[k];
            rel[k] = wint_t'(ray_org[k]);
            rel[k] = rel[k] - va[k];
            dv[k] = wint_t'(ray_dir[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            nrm[k] = e1[rti_pkg::NXT[k]] * e2[rti_pkg::PRV[k]]
                   - e1[rti_pkg::PRV[k]] * e2[rti_pkg::NXT[k]];
            crs[k] = rel[rti_pkg::NXT[k]] * dv[rti_pkg::PRV[k]]
                   - rel[rti_pkg::PRV[k]] * dv[rti_pkg::NXT[k]];
        end
        dsc = -(dv[0] * nrm[0] + dv[1] * nrm[1] + dv[2] * nrm[2]);
        un = e2[0] * crs[0] + e2[1] * crs[1] + e2[2] * crs[2];
        vn = -(e1[0] * crs[0] + e1[1] * crs[1] + e1[2] * crs[2]);
        tn = rel[0] * nrm[0] + rel[1] * nrm[1] + rel[2] * nrm[2];
        thr = wint_t'(det_floor);
        if (det_floor == 0)
            thr = 1;
        thr = thr <<< 32;
        r = '{0, 0, 0, 0};
        if (dsc >= thr && tn >= 0 && un >= 0 && vn >= 0 && un + vn <= dsc)
        begin
            r.hit = 1;
            r.x = hit_coord(wint_t'(ray_org[0]), dv[0], tn, dsc);
            r.y = hit_coord(wint_t'(ray_org[1]), dv[1], tn, dsc);
            r.z = hit_coord(wint_t'(ray_org[2]), dv[2], tn, dsc);
        end
        return r;
    endfunction

    function automatic tri_t tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
        tri_t t;
        t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
        errors++;
        $display("mismatch on item %0d: %s got %0h expected %0h", n_checked, what, got, want);
    endtask

    task automatic write_reg(logic [rti_pkg::IW-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rti_pkg::REG_ORIGIN_X: ray_org[0] = data;
            rti_pkg::REG_ORIGIN_Y: ray_org[1] = data;
            rti_pkg::REG_ORIGIN_Z: ray_org[2] = data;
            rti_pkg::REG_DIR_X:    ray_dir[0] = data;
            rti_pkg::REG_DIR_Y:    ray_dir[1] = data;
            rti_pkg::REG_DIR_Z:    ray_dir[2] = data;
            rti_pkg::REG_DET_MIN:  det_floor = data[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (isect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_tri(tri_t t, logic typed, isect_t want);
        int gap;
        @(negedge clk);
        in_valid <= 1;
        {a_x, a_y, a_z} <= {t.v[0], t.v[1], t.v[2]};
        {b_x, b_y, b_z} <= {t.v[3], t.v[4], t.v[5]};
        {c_x, c_y, c_z} <= {t.v[6], t.v[7], t.v[8]};
        do @(posedge clk); while (!in_ready);
        isect_q.push_back(typed ? want : predict_isect(t));
        n_tris++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // triangle near a point on the ray, random winding, sometimes behind the origin
    function automatic tri_t ray_tri();
        tri_t t;
        longint p;
        int k;
        k = $urandom_range(0, 4) - 1;
        for (int c = 0; c < 3; c++)
        begin
            p = longint'(ray_org[c]) + longint'(ray_dir[c]) * k;
            for (int j = 0; j < 3; j++)
                t.v[3*j+c] = 32'(p + $signed($urandom_range(0, 6 * ONE)) - 3 * ONE);
        end
        return t;
    endfunction

    function automatic tri_t noise_tri();
        tri_t t;
        for (int j = 0; j < 9; j++)
            t.v[j] = $urandom();
        return t;
    endfunction

    // receiver stall pattern rotates through always ready, random and periodic modes
    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc / 400) % 3)
            0: out_ready <= 1;
            1: out_ready <= ($urandom_range(0, 99) < 60);
            default: out_ready <= ((cyc % 16) >= 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (isect_q.size() == 0)
            begin
                errors++;
                $display("unexpected result item: hit %0b", hit);
            end
            else
            begin
                isect_t w;
                w = isect_q.pop_front();
                if (hit !== w.hit)
                    report("hit", hit, w.hit);
                if (hit_x !== w.x)
                    report("hit_x", hit_x, w.x);
                if (hit_y !== w.y)
                    report("hit_y", hit_y, w.y);
                if (hit_z !== w.z)
                    report("hit_z", hit_z, w.z);
                n_hits += w.hit;
            end
            n_checked++;
        end
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", isect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        isect_t miss;
        isect_t none;
        logic [31:0] d;
        miss = '{0, 0, 0, 0};
        none = miss;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        det_floor = 1;

        // front face straight ahead at z=1 is hit at (0,0,1)
        rows.push_back('{tri_of(-ONE, -ONE, ONE, -ONE, 2*ONE, ONE, 2*ONE, -ONE, ONE),
                         1, '{1, 0, 0, ONE}});
        // same triangle wound the other way is culled
        rows.push_back('{tri_of(-ONE, -ONE, ONE, 2*ONE, -ONE, ONE, -ONE, 2*ONE, ONE),
                         1, miss});
        // behind the origin
        rows.push_back('{tri_of(-ONE, -ONE, -ONE, -ONE, 2*ONE, -ONE, 2*ONE, -ONE, -ONE),
                         1, miss});
        // degenerate
        rows.push_back('{tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, miss});
        rows.push_back('{tri_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1, miss});
        // ray through a vertex, through an edge, and at t = 0
        rows.push_back('{tri_of(0, 0, ONE, 0, 3*ONE, ONE, 3*ONE, 0, ONE), 0, none});
        rows.push_back('{tri_of(-ONE, 0, ONE, -ONE, 2*ONE, ONE, ONE, 0, ONE), 0, none});
        rows.push_back('{tri_of(-ONE, -ONE, 0, -ONE, 2*ONE, 0, 2*ONE, -ONE, 0), 0, none});
        // coordinate extremes
        rows.push_back('{tri_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff), 1, miss});
        rows.push_back('{tri_of(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff), 0, none});
        rows.push_back('{tri_of(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                32'h80000000), 0, none});
        rows.push_back('{tri_of(32'h80000000, 32'h80000000, 1, 32'h80000000, 32'h7fffffff, 1,
                                32'h7fffffff, 32'h80000000, 1), 0, none});
        rows.push_back('{tri_of(-1, -1, 32'h7fffffff, -1, 1, 32'h7fffffff, 1, -1,
                                32'h7fffffff), 0, none});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        foreach (rows[i])
            send_tri(rows[i].t, rows[i].typed, rows[i].want);

        for (int ph = 1; ph <= 6; ph++)
        begin
            @(negedge clk);
            in_valid <= 0;
            wait_idle();
            for (int r = 0; r < 7; r++)
            begin
                case (ph)
                    1: d = (r == 6) ? 32'h7fffffff : 32'h7fffffff;
                    2: d = (r == 6) ? 32'h80000000 : 32'h80000000;
                    3: d = (r < 3) ? 0 : (r == 6 ? 32'h7fffffff : ONE);
                    default:
                        if (r < 3)
                            d = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
                        else if (r < 6)
                            d = ($urandom_range(0, 5) == 0) ? 0 :
                                $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
                        else
                            d = $urandom_range(1, 2 * ONE);
                endcase
                write_reg(rti_pkg::rti_reg_t'(r), d);
            end
            if (ph == 1)
                write_reg(REG_UNUSED, $urandom());
            for (int i = 0; i < 320; i++)
                send_tri(($urandom_range(0, 9) < 8) ? ray_tri() : noise_tri(), 0, none);
        end

        @(negedge clk);
        in_valid <= 0;
        wait_idle();
        $display("%0d triangles sent over 7 ray settings, %0d results checked, %0d hits",
                 n_tris, n_checked, n_hits);
        $display("errors: %0d, results left over: %0d", errors, isect_q.size());
        if (errors == 0 && isect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
